// ===== src/jacobi_symbol_defines.svh =====
// ============================================================================
// Jacobi symbol assertion macros
// Shared forms for the concurrent checks on the jacobi_symbol ports.
// ============================================================================
`ifndef JACOBI_SYMBOL_DEFINES_SVH
`define JACOBI_SYMBOL_DEFINES_SVH

// Clocked check, skipped while reset is held.
`define JAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define JAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/jac_pkg.sv =====
// ============================================================================
// Jacobi symbol package
// Item types, controller states and the controller/datapath interface.
// ============================================================================
package jac_pkg;

    localparam int FIELD_BITS      = 64;
    localparam int WORD_BITS_DEF   = 64;

    localparam logic OP_UNSIGNED   = 1'b0;
    localparam logic OP_SIGNED     = 1'b1;

    localparam logic signed [1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;

    typedef struct packed {
        logic                  op;
        logic [FIELD_BITS-1:0] x_value;
        logic [FIELD_BITS-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic signed [1:0] symbol;
        logic              invalid;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic finished;
    } t_status;

endpackage

// ===== src/jac_datapath.sv =====
// ============================================================================
// Jacobi symbol datapath
// Binary reduction: one shift, swap or subtract per step, plus sign tracking.
// ============================================================================
module jac_datapath #(
    parameter int WORD_BITS = jac_pkg::WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  jac_pkg::t_in   i_item,
    input  jac_pkg::t_cmd  i_cmd,
    output jac_pkg::t_status o_status,
    output jac_pkg::t_out  o_result
);

    logic [WORD_BITS-1:0] r_a, n_a;
    logic [WORD_BITS-1:0] r_n, n_n;
    logic                 r_t, n_t;     // 1: symbol is negated
    logic                 r_inv, n_inv;
    jac_pkg::t_out        r_res, n_res;

    logic [WORD_BITS-1:0] x_in, y_in, x_neg, diff;
    logic                 neg;
    logic                 n_is_one;

    assign x_in  = i_item.x_value[WORD_BITS-1:0];
    assign y_in  = i_item.modulus[WORD_BITS-1:0];
    assign x_neg = '0 - x_in;
    assign neg   = (i_item.op == jac_pkg::OP_SIGNED) && x_in[WORD_BITS-1];
    assign diff  = r_a - r_n;
    assign n_is_one = (r_n == {{(WORD_BITS-1){1'b0}}, 1'b1});

    assign o_status.finished = r_inv || (r_a == '0);

    always_comb begin
        n_a   = r_a;
        n_n   = r_n;
        n_t   = r_t;
        n_inv = r_inv;
        n_res = r_res;
        if (i_cmd.load) begin
            n_a   = neg ? x_neg : x_in;
            n_n   = y_in;
            // (-1/y) = -1 when y = 3 mod 4
            n_t   = neg && y_in[1];
            n_inv = !y_in[0];
        end else if (i_cmd.step) begin
            if (!r_a[0]) begin
                // (2/n) = -1 when n = 3 or 5 mod 8
                n_a = r_a >> 1;
                n_t = r_t ^ (r_n[1] ^ r_n[2]);
            end else if (r_a < r_n) begin
                // reciprocity: flip when both are 3 mod 4
                n_a = r_n;
                n_n = r_a;
                n_t = r_t ^ (r_a[1] & r_n[1]);
            end else begin
                n_a = diff;
            end
        end
        if (i_cmd.finish) begin
            n_res.invalid = r_inv;
            if (r_inv || !n_is_one) begin
                n_res.symbol = jac_pkg::SYM_ZERO;
            end else begin
                n_res.symbol = r_t ? jac_pkg::SYM_NEG : jac_pkg::SYM_POS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_n   <= n_n;
        r_t   <= n_t;
        r_inv <= n_inv;
        r_res <= n_res;
    end

    assign o_result = r_res;

endmodule

// ===== src/jac_ctrl.sv =====
// ============================================================================
// Jacobi symbol controller
// Sequences load, reduction steps and the one-cycle result strobe.
// ============================================================================
module jac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  jac_pkg::t_status i_status,
    output jac_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    jac_pkg::t_state r_state, n_state;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jac_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            jac_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = jac_pkg::ST_RUN;
                end
            end
            jac_pkg::ST_RUN: begin
                if (i_status.finished) begin
                    o_cmd.finish = 1'b1;
                    n_state      = jac_pkg::ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = jac_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state == jac_pkg::ST_RUN);
    assign o_done = r_done;

endmodule

// ===== src/jacobi_symbol.sv =====
// ============================================================================
// Jacobi symbol unit
// Computes (x/y) for a WORD_BITS-bit x over an odd modulus y: -1, 0 or +1.
// ============================================================================
// Usage:
//   Input: drive i_item and raise start; the item is taken at a clock edge
//   where start is high and busy is low. busy stays high while it reduces.
//   Output: o_done pulses for exactly one cycle with o_result valid; there
//   is no back-pressure, so the receiver must take the item in that cycle.
//   Result register is separate from the working registers, so a new item
//   may be started in the cycle o_done is shown.
//   Each reduction step is one shift, swap or WORD_BITS-bit subtract; the
//   number of steps depends on the operands. An even or zero modulus ends
//   after the load with invalid set and symbol 0.
//   Throughput: one item at a time; the next may start on the done cycle.
//   Reset (i_rst_n low, synchronous) returns the controller to idle and
//   drops any item in flight without a result.
// ============================================================================
module jacobi_symbol #(
    parameter int WORD_BITS = jac_pkg::WORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  jac_pkg::t_in  i_item,
    output logic          o_done,
    output jac_pkg::t_out o_result
);

    jac_pkg::t_cmd    cmd;
    jac_pkg::t_status status;

    // sequencing: idle -> run (steps) -> idle with a result strobe
    jac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // operand registers, sign tracking and result register
    jac_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

// ===== src/jac_chk.sv =====
// ============================================================================
// Jacobi symbol port checker
// Checks handshake sequencing and result encoding seen at the top level.
// ============================================================================
`include "jacobi_symbol_defines.svh"

module jac_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input jac_pkg::t_out o_result
);

    `JAC_ASSERT(a_take_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted item did not raise busy")
    `JAC_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobe while busy")
    `JAC_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "result strobe longer than one cycle")
    `JAC_ASSERT(a_inv_zero, i_clk, i_rst_n, (o_done && o_result.invalid) |-> (o_result.symbol == jac_pkg::SYM_ZERO), "invalid result with nonzero symbol")
    `JAC_ASSERT_ALWAYS(a_sym_code, i_clk, o_done |-> (o_result.symbol != 2'sb10), "illegal symbol code")

endmodule

bind jacobi_symbol jac_chk u_jac_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== dv/jacobi_symbol_test.sv =====
// ============================================================================
// Jacobi symbol unit testbench
// Feeds signed and unsigned numerators over odd, even, tiny and full-width
// moduli, predicts each symbol in the bench, and checks every o_done item
// in order against that prediction.
// ============================================================================
module jacobi_symbol_test;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4 * jac_pkg::FIELD_BITS + 40;
    // Sized for under a thousand items with their busy time and idle gaps; this leaves a wide margin.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RANDOM_PER_PHASE = 300;

    // Gap profiles for the sender.
    localparam int GAPS_NONE  = 0;
    localparam int GAPS_MIXED = 1;
    localparam int GAPS_SHORT = 2;

    // One queued job: either an item with the idle gap that follows it,
    // or a drain marker that holds the sender until nothing is owed.
    typedef struct {
        jac_pkg::t_in item;
        int unsigned  gap;
        bit           drain;
    } t_jacobi_job;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    jac_pkg::t_in  i_item  = '0;
    logic          busy;
    logic          o_done;
    jac_pkg::t_out o_result;

    t_jacobi_job   job_queue[$];
    jac_pkg::t_out symbol_due[$];

    // Handshake seen at the last rising edge, read by the driver.
    logic        item_taken = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned gap_after  = 0;

    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned n_pos       = 0;
    int unsigned n_neg       = 0;
    int unsigned n_zero      = 0;
    int unsigned n_invalid   = 0;

    jacobi_symbol DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Symbol predictor. Euclidean reduction: pull out factors of two
    // (sign flips when the modulus is 3 or 5 mod 8), swap with the
    // reciprocity flip when both are 3 mod 4, then reduce. A negative
    // signed numerator is replaced by its magnitude, with a flip when the
    // modulus is 3 mod 4; the most negative value stays 2^63 unsigned.
    // ------------------------------------------------------------------
    function automatic jac_pkg::t_out jacobi_of(jac_pkg::t_in item);
        jac_pkg::t_out                  res;
        logic [jac_pkg::FIELD_BITS-1:0] num;
        logic [jac_pkg::FIELD_BITS-1:0] den;
        logic [jac_pkg::FIELD_BITS-1:0] swap;
        int                             sgn;
        bit                             neg_flip;
        res = '0;
        if (!item.modulus[0]) begin
            // even or zero modulus: flagged, symbol stays zero
            res.invalid = 1'b1;
            return res;
        end
        num      = item.x_value;
        den      = item.modulus;
        neg_flip = 1'b0;
        if (item.op == jac_pkg::OP_SIGNED && num[jac_pkg::FIELD_BITS-1]) begin
            num      = -num;
            neg_flip = (den[1:0] == 2'd3);
        end
        sgn = 1;
        num = num % den;
        while (num != 0) begin
            while (!num[0]) begin
                num = num >> 1;
                if (den[2:0] == 3'd3 || den[2:0] == 3'd5)
                    sgn = -sgn;
            end
            swap = num;
            num  = den;
            den  = swap;
            if (num[1:0] == 2'd3 && den[1:0] == 2'd3)
                sgn = -sgn;
            num = num % den;
        end
        // leftover den above one means a shared factor
        if (den != 1)
            sgn = 0;
        if (neg_flip)
            sgn = -sgn;
        res.symbol = (sgn > 0) ? jac_pkg::SYM_POS :
                     (sgn < 0) ? jac_pkg::SYM_NEG : jac_pkg::SYM_ZERO;
        return res;
    endfunction

    function automatic logic [jac_pkg::FIELD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap(int profile);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (profile)
            GAPS_NONE:  return 0;
            GAPS_MIXED: begin
                if (roll < 65) return 0;
                if (roll < 90) return $urandom_range(1, 4);
                return $urandom_range(20, 200);
            end
            default: begin
                if (roll < 50) return 0;
                if (roll < 97) return $urandom_range(1, 3);
                return $urandom_range(30, 120);
            end
        endcase
    endfunction

    task automatic queue_item(logic op, logic [jac_pkg::FIELD_BITS-1:0] x,
                              logic [jac_pkg::FIELD_BITS-1:0] y, int profile);
        t_jacobi_job job;
        job.item.op      = op;
        job.item.x_value = x;
        job.item.modulus = y;
        job.gap          = pick_gap(profile);
        job.drain        = 1'b0;
        job_queue.push_back(job);
    endtask

    task automatic queue_drain();
        t_jacobi_job job;
        job.item  = '0;
        job.gap   = 0;
        job.drain = 1'b1;
        job_queue.push_back(job);
    endtask

    // Random item with a bias toward the interesting corners: small and
    // tiny moduli, shared factors, negatives, even moduli, modulus one.
    task automatic queue_random(int profile);
        logic [jac_pkg::FIELD_BITS-1:0] x;
        logic [jac_pkg::FIELD_BITS-1:0] y;
        logic                           op;
        int unsigned                    roll;
        op   = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll == 0)
            y = '0;
        else if (roll < 8)
            y = rand_word() & ~64'd1;
        else if (roll < 10)
            y = 64'd1;
        else if (roll < 40)
            y = 64'($urandom_range(1, 2000)) | 64'd1;
        else if (roll < 55)
            y = {32'd0, $urandom} | 64'd1;
        else
            y = rand_word() | 64'd1;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            x = '0;
        else if (roll < 10)
            x = ($urandom_range(0, 1)) ? {1'b1, 63'd0} : '1;
        else if (roll < 30) begin
            x = 64'($urandom_range(0, 5000));
            if ($urandom_range(0, 1))
                x = -x;
        end else if (roll < 45 && y < 64'd3000)
            x = y * 64'($urandom_range(1, 1000));    // shared factor
        else
            x = rand_word();
        queue_item(op, x, y, profile);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed corners, then three random phases with different
    // sender gap profiles; the corners and first two phases end in a drain.
    // ------------------------------------------------------------------
    initial begin
        // even and zero moduli, with signed negative x too
        queue_item(jac_pkg::OP_UNSIGNED, 64'd5, 64'd2, GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, 64'd7, 64'd0, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, '1, 64'hFFFF_FFFF_FFFF_FFFE, GAPS_MIXED);
        // modulus one gives +1 for any x, zero included
        queue_item(jac_pkg::OP_UNSIGNED, 64'd0, 64'd1, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, '1, 64'd1, GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, '1, 64'd1, GAPS_MIXED);
        // zero numerator over a real modulus
        queue_item(jac_pkg::OP_UNSIGNED, 64'd0, 64'd15, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, 64'd0, '1, GAPS_MIXED);
        // shared factor
        queue_item(jac_pkg::OP_UNSIGNED, 64'd21, 64'd15, GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, 64'd12345, 64'd12345, GAPS_MIXED);
        // small textbook values: (2/3), (2/7), (-1/7), (-1/5)
        queue_item(jac_pkg::OP_UNSIGNED, 64'd2, 64'd3, GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, 64'd2, 64'd7, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, '1, 64'd7, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, '1, 64'd5, GAPS_MIXED);
        // same bit pattern as unsigned and as signed
        queue_item(jac_pkg::OP_UNSIGNED, '1, 64'd7, GAPS_MIXED);
        // most negative x over moduli 3 and 1 mod 4
        queue_item(jac_pkg::OP_SIGNED, {1'b1, 63'd0}, '1, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, {1'b1, 63'd0}, 64'hFFFF_FFFF_FFFF_FFC5,
                   GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, {1'b1, 63'd0}, 64'hFFFF_FFFF_FFFF_FFC5,
                   GAPS_MIXED);
        // full-width extremes, x above modulus, largest 64-bit prime
        queue_item(jac_pkg::OP_UNSIGNED, '1, '1, GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, '1, 64'hFFFF_FFFF_FFFF_FFC5, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, {1'b0, {63{1'b1}}}, 64'hFFFF_FFFF_FFFF_FFC5,
                   GAPS_MIXED);
        queue_item(jac_pkg::OP_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h5555_5555_5555_5555, GAPS_MIXED);
        queue_item(jac_pkg::OP_SIGNED, 64'h8000_0000_0000_0001, 64'd3, GAPS_MIXED);
        queue_drain();

        repeat (RANDOM_PER_PHASE) queue_random(GAPS_NONE);
        queue_drain();
        repeat (RANDOM_PER_PHASE) queue_random(GAPS_MIXED);
        queue_drain();
        repeat (RANDOM_PER_PHASE) queue_random(GAPS_SHORT);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for the sender to run dry and every result to come back
        while (job_queue.size() != 0 || start || symbol_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d of +1, %0d of -1, %0d of 0, %0d invalid.",
                 items_sent, n_pos, n_neg, n_zero, n_invalid);
        $display("Signed and unsigned x, tiny to full-width moduli, gaps and drains.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("%0t: timeout, %0d results still owed", $time, symbol_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. Works on the falling edge; start is written once per edge.
    // After an item is taken it idles for that item's gap, then presents
    // the next one. A drain marker holds it until nothing is owed.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic        next_start;
        t_jacobi_job job;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && item_taken) begin
                next_start = 1'b0;
                gap_left   = gap_after;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_queue.size() != 0) begin
                    if (job_queue[0].drain) begin
                        if (symbol_due.size() == 0 && !busy)
                            void'(job_queue.pop_front());
                    end else begin
                        job        = job_queue.pop_front();
                        i_item     <= job.item;
                        gap_after  = job.gap;
                        next_start = 1'b1;
                    end
                end
            end
        end
        start <= next_start;
    end

    // ------------------------------------------------------------------
    // Acceptance and result check on the rising edge. An item taken here
    // gets its prediction queued; each o_done item is matched against the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        jac_pkg::t_out want;
        item_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            symbol_due.push_back(jacobi_of(i_item));
            items_sent++;
        end
        if (i_rst_n && o_done) begin
            if (symbol_due.size() == 0) begin
                $display("%0t: result with none owed: symbol %0d invalid %0b",
                         $time, o_result.symbol, o_result.invalid);
                errors++;
            end else begin
                want = symbol_due.pop_front();
                if (o_result.symbol !== want.symbol) begin
                    $display("%0t: symbol mismatch: expected %0d, got %0d",
                             $time, want.symbol, o_result.symbol);
                    errors++;
                end
                if (o_result.invalid !== want.invalid) begin
                    $display("%0t: invalid mismatch: expected %0b, got %0b",
                             $time, want.invalid, o_result.invalid);
                    errors++;
                end
                if (want.invalid)
                    n_invalid++;
                else if (want.symbol == jac_pkg::SYM_POS)
                    n_pos++;
                else if (want.symbol == jac_pkg::SYM_NEG)
                    n_neg++;
                else
                    n_zero++;
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+src
src/jac_pkg.sv
src/jac_datapath.sv
src/jac_ctrl.sv
src/jacobi_symbol.sv
src/jac_chk.sv
dv/jacobi_symbol_test.sv
